### rtl/pqd_pkg.sv
`timescale 1ns / 1ps
// Package for the palette quantizer and dirty cell packer.
// Holds sizes, item and command types, the fixed color table and address helpers.
// No dependencies.
package pqd_pkg;

    // Sizes
    localparam int NUM_PALETTES  = 14;
    localparam int FRAME_CELLS   = 8000;
    localparam int PAL_ENTRIES   = 256;
    localparam int MAP_DEPTH     = NUM_PALETTES * PAL_ENTRIES;
    localparam int MAP_AW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int SHADOW_AW     = (FRAME_CELLS > 1) ? $clog2(FRAME_CELLS) : 1;
    localparam int CELL_W        = 13;
    localparam int SEL_W         = 4;
    localparam int CODE_W        = 4;
    localparam int PIX_W         = 8;
    localparam int LEVEL_W       = 8;
    localparam int DIST_W        = 10;
    localparam int ROOT_W        = 5;
    localparam int NUM_COLORS    = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = 2;

    // Values
    localparam logic [PIX_W-1:0]  SHADOW_RESET = 8'hDE;
    localparam logic [5:0]        LVL_LO       = 6'h15;
    localparam logic [5:0]        LVL_MID      = 6'h2A;
    localparam logic [5:0]        LVL_HI       = 6'h3F;
    localparam logic [SEL_W:0]    NUM_PAL_V    = (SEL_W+1)'(NUM_PALETTES);
    localparam logic [CELL_W-1:0] LAST_CELL    = CELL_W'(FRAME_CELLS - 1);

    typedef enum logic {
        OP_MATCH = 1'b0,
        OP_PIXEL = 1'b1
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [SEL_W-1:0]   palette_number;
        logic [PIX_W-1:0]   color_index;
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
        logic [PIX_W-1:0]   left_pixel;
        logic [PIX_W-1:0]   right_pixel;
    } t_in_item;

    typedef struct packed {
        logic [CELL_W-1:0] cell_index;
        logic [PIX_W-1:0]  cell_byte;
    } t_out_item;

    // Command passed from the front end to the back end
    typedef struct packed {
        t_op               op;
        logic [MAP_AW-1:0] map_addr;
        logic [CODE_W-1:0] code;
        logic [PIX_W-1:0]  left_pixel;
        logic [PIX_W-1:0]  right_pixel;
    } t_cmd;

    // Fixed 16-color set, packed as {red, green, blue}
    function automatic logic [17:0] fixed_color(input logic [CODE_W-1:0] j);
        logic [17:0] c;
        unique case (j)
            4'd0:    c = {6'h00,   6'h00,   6'h00};
            4'd1:    c = {6'h00,   6'h00,   LVL_MID};
            4'd2:    c = {6'h00,   LVL_MID, 6'h00};
            4'd3:    c = {6'h00,   LVL_MID, LVL_MID};
            4'd4:    c = {LVL_MID, 6'h00,   6'h00};
            4'd5:    c = {LVL_MID, 6'h00,   LVL_MID};
            4'd6:    c = {LVL_MID, LVL_LO,  6'h00};
            4'd7:    c = {LVL_MID, LVL_MID, LVL_MID};
            4'd8:    c = {LVL_LO,  LVL_LO,  LVL_LO};
            4'd9:    c = {LVL_LO,  LVL_LO,  LVL_HI};
            4'd10:   c = {LVL_LO,  LVL_HI,  LVL_LO};
            4'd11:   c = {LVL_LO,  LVL_HI,  LVL_HI};
            4'd12:   c = {LVL_HI,  LVL_LO,  LVL_LO};
            4'd13:   c = {LVL_HI,  LVL_LO,  LVL_HI};
            4'd14:   c = {LVL_HI,  LVL_HI,  LVL_LO};
            default: c = {LVL_HI,  LVL_HI,  LVL_HI};
        endcase
        return c;
    endfunction

    // Color map address: palette * 256 + pixel
    function automatic logic [MAP_AW-1:0] map_addr(input logic [SEL_W-1:0] pal,
                                                   input logic [PIX_W-1:0] pix);
        logic [SEL_W+PIX_W-1:0] full;
        full = {pal, pix};
        return full[MAP_AW-1:0];
    endfunction

endpackage

### rtl/pqd_ram.sv
`timescale 1ns / 1ps
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module pqd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, and read both ports on enable; hold read data otherwise
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

### rtl/pqd_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, forwards pixel pairs, and runs the nearest
// color search (L1 distance, floor square root) for match requests. Uses pqd_pkg.
module pqd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pqd_pkg::t_in_item i_item,
    output logic              o_push_valid,
    input  logic              i_push_ready,
    output pqd_pkg::t_cmd     o_push_cmd
);
    import pqd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIST = 4'b0010,
        S_ROOT = 4'b0100,
        S_PUSH = 4'b1000
    } t_fstate;

    t_fstate             r_state, n_state;
    logic [CODE_W-1:0]   r_j, n_j;
    logic [LEVEL_W-1:0]  r_red, r_green, r_blue;
    logic [SEL_W-1:0]    r_pal;
    logic [PIX_W-1:0]    r_idx;
    logic [DIST_W-1:0]   r_dist, n_dist;
    logic [ROOT_W-1:0]   r_root, n_root;
    logic [ROOT_W-1:0]   r_bit, n_bit;
    logic [ROOT_W-1:0]   r_best, n_best;
    logic [CODE_W-1:0]   r_code, n_code;

    logic [17:0]         color;
    logic [LEVEL_W-1:0]  ad_r, ad_g, ad_b;
    logic [ROOT_W-1:0]   trial;
    logic [DIST_W-1:0]   trial_sq;
    logic [ROOT_W-1:0]   root_next;
    logic                accept;
    logic                pal_ok;

    function automatic logic [LEVEL_W-1:0] abs_diff(input logic [LEVEL_W-1:0] a,
                                                     input logic [LEVEL_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign color = fixed_color(r_j);
    assign ad_r  = abs_diff({2'b00, color[17:12]}, r_red);
    assign ad_g  = abs_diff({2'b00, color[11:6]},  r_green);
    assign ad_b  = abs_diff({2'b00, color[5:0]},   r_blue);

    // One root bit per cycle: keep the trial bit if its square fits
    assign trial     = r_root | r_bit;
    assign trial_sq  = {5'b0, trial} * {5'b0, trial};
    assign root_next = (trial_sq <= r_dist) ? trial : r_root;

    assign pal_ok  = ({1'b0, r_pal} < NUM_PAL_V);
    assign o_ready = (r_state == S_IDLE) && i_push_ready;
    assign accept  = i_valid && o_ready;

    // Pixel pairs go straight to the queue; finished matches push their map write when the palette number is in range
    always_comb begin
        o_push_valid = 1'b0;
        o_push_cmd   = '0;
        if (r_state == S_PUSH) begin
            o_push_valid        = pal_ok;
            o_push_cmd.op       = OP_MATCH;
            o_push_cmd.map_addr = map_addr(r_pal, r_idx);
            o_push_cmd.code     = r_code;
        end else if (r_state == S_IDLE) begin
            o_push_valid           = i_valid && (i_item.op == OP_PIXEL);
            o_push_cmd.op          = OP_PIXEL;
            o_push_cmd.left_pixel  = i_item.left_pixel;
            o_push_cmd.right_pixel = i_item.right_pixel;
        end
    end

    // Search sequencer
    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        n_dist  = r_dist;
        n_root  = r_root;
        n_bit   = r_bit;
        n_best  = r_best;
        n_code  = r_code;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_item.op == OP_MATCH)) begin
                    n_state = S_DIST;
                    n_j     = '0;
                end
            end
            S_DIST: begin
                n_dist  = DIST_W'(ad_r) + DIST_W'(ad_g) + DIST_W'(ad_b);
                n_root  = '0;
                n_bit   = ROOT_W'(1) << (ROOT_W - 1);
                n_state = S_ROOT;
            end
            S_ROOT: begin
                n_root = root_next;
                n_bit  = r_bit >> 1;
                if (r_bit[0]) begin
                    // Strictly smaller root wins, so ties keep the earlier color
                    if ((r_j == '0) || (root_next < r_best)) begin
                        n_best = root_next;
                        n_code = r_j;
                    end
                    if (r_j == CODE_W'(NUM_COLORS - 1)) begin
                        n_state = S_PUSH;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = S_DIST;
                    end
                end
            end
            S_PUSH: begin
                if (!pal_ok || i_push_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_j    <= n_j;
        r_dist <= n_dist;
        r_root <= n_root;
        r_bit  <= n_bit;
        r_best <= n_best;
        r_code <= n_code;
        if (accept && (i_item.op == OP_MATCH)) begin
            r_red   <= i_item.red_level;
            r_green <= i_item.green_level;
            r_blue  <= i_item.blue_level;
            r_pal   <= i_item.palette_number;
            r_idx   <= i_item.color_index;
        end
    end

endmodule

### rtl/pqd_queue.sv
`timescale 1ns / 1ps
// Small command FIFO between front and back end.
// Uses pqd_pkg for the command type and depth.
module pqd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  pqd_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output pqd_pkg::t_cmd o_pop_cmd
);
    import pqd_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr, r_rptr;
    logic [QUEUE_AW:0]   r_count;
    logic                push, pop;

    assign o_push_ready = (r_count != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_cmd;
        end
    end

endmodule

### rtl/pqd_back.sv
`timescale 1ns / 1ps
// Back end: writes the color map, translates pixel pairs, compares against the
// shadow store and emits changed cells. Uses pqd_pkg and pqd_ram.
module pqd_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    output logic                      o_cmd_ready,
    input  pqd_pkg::t_cmd             i_cmd,
    input  logic [pqd_pkg::SEL_W-1:0] i_palette_select,
    output logic                      o_valid,
    input  logic                      i_ready,
    output pqd_pkg::t_out_item        o_item
);
    import pqd_pkg::*;

    logic              issue, issue_pix, issue_match;
    logic              sel_ok;
    logic [CODE_W-1:0] map_a, map_b;
    logic [PIX_W-1:0]  shadow_rd;

    logic              r_s2_valid;
    logic [CELL_W-1:0] r_s2_pos;
    logic              r_s2_lap;
    logic              r_s2_sel_ok;
    logic              r_s2_fwd;
    logic [PIX_W-1:0]  r_s2_fwd_byte;
    logic [CELL_W-1:0] r_pos;
    logic              r_lap;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [PIX_W-1:0]  s2_byte, s2_old;
    logic              s2_differ, s2_done, out_free;

    assign sel_ok = ({1'b0, i_palette_select} < NUM_PAL_V);

    // Stage 2 compare and hand-off
    assign s2_byte   = r_s2_sel_ok ? {map_a, map_b} : '0;
    assign s2_old    = r_s2_fwd ? r_s2_fwd_byte : (r_s2_lap ? shadow_rd : SHADOW_RESET);
    assign s2_differ = (s2_byte != s2_old);
    assign out_free  = !r_out_valid || i_ready;
    assign s2_done   = r_s2_valid && (!s2_differ || out_free);

    // Issue one command a cycle while stage 2 is free or draining
    assign issue       = i_cmd_valid && (!r_s2_valid || s2_done);
    assign issue_pix   = issue && (i_cmd.op == OP_PIXEL);
    assign issue_match = issue && (i_cmd.op == OP_MATCH);
    assign o_cmd_ready = !r_s2_valid || s2_done;

    pqd_ram #(
        .WIDTH (CODE_W),
        .DEPTH (MAP_DEPTH)
    ) u_color_map (
        .i_clk     (i_clk),
        .i_we      (issue_match),
        .i_waddr   (i_cmd.map_addr),
        .i_wdata   (i_cmd.code),
        .i_re      (issue_pix),
        .i_raddr_a (map_addr(i_palette_select, i_cmd.left_pixel)),
        .i_raddr_b (map_addr(i_palette_select, i_cmd.right_pixel)),
        .o_rdata_a (map_a),
        .o_rdata_b (map_b)
    );

    // Every pixel pair writes its byte back, so the store is filled in cell order
    pqd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (FRAME_CELLS)
    ) u_shadow (
        .i_clk     (i_clk),
        .i_we      (s2_done),
        .i_waddr   (r_s2_pos[SHADOW_AW-1:0]),
        .i_wdata   (s2_byte),
        .i_re      (issue_pix),
        .i_raddr_a (r_pos[SHADOW_AW-1:0]),
        .i_raddr_b (r_pos[SHADOW_AW-1:0]),
        .o_rdata_a (shadow_rd),
        .o_rdata_b ()
    );

    // Control: stage 2 valid, cell counter, first-frame flag, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_pos       <= '0;
            r_lap       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (issue_pix) begin
                r_s2_valid <= 1'b1;
            end else if (s2_done) begin
                r_s2_valid <= 1'b0;
            end
            if (issue_pix) begin
                if (r_pos == LAST_CELL) begin
                    r_pos <= '0;
                    r_lap <= 1'b1;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            if (s2_done && s2_differ) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: stage 2 context and output register
    always_ff @(posedge i_clk) begin
        if (issue_pix) begin
            r_s2_pos      <= r_pos;
            r_s2_lap      <= r_lap;
            r_s2_sel_ok   <= sel_ok;
            // Bypass a write to the same cell that lands on this edge
            r_s2_fwd      <= s2_done && (r_s2_pos == r_pos);
            r_s2_fwd_byte <= s2_byte;
        end
        if (s2_done && s2_differ) begin
            r_out.cell_index <= r_s2_pos;
            r_out.cell_byte  <= s2_byte;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

### rtl/palette_quantize_and_dirty_cell_pack.sv
`timescale 1ns / 1ps
// Top level of the palette quantizer and dirty cell packer.
// Depends on pqd_pkg, pqd_front, pqd_queue, pqd_back (and pqd_ram below it).
//
//   Channel   Signals                      Direction  Carries
//   request   i_valid / o_ready / i_item   in         match or pixel-pair request
//   result    o_valid / i_ready / o_item   out        changed cell index and byte
//   config    i_cfg_we / i_cfg_wdata       in         palette_select
//
// A new pixel pair can be taken every cycle while the front end is idle and
// the queue has room; a changed cell passes the queue entry, the registered
// color map and shadow reads and the output register before it is offered.
// A match request holds the front end while the shared distance and bit-serial
// square root unit works through the 16 colors. A four-entry queue separates
// front and back, so a stalled result only blocks input once the queue is full.
// After reset the shadow store reads as 0xDE until the first frame pass writes it.
module palette_quantize_and_dirty_cell_pack (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  pqd_pkg::t_in_item         i_item,
    output logic                      o_valid,
    input  logic                      i_ready,
    output pqd_pkg::t_out_item        o_item,
    input  logic                      i_cfg_we,
    input  logic [pqd_pkg::SEL_W-1:0] i_cfg_wdata
);
    import pqd_pkg::*;

    logic             r_palette_select;
    logic [SEL_W-1:0] r_pal_sel;
    logic             push_valid, push_ready, pop_valid, pop_ready;
    t_cmd             push_cmd, pop_cmd;

    // Hold the palette select register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_sel <= '0;
        end else if (i_cfg_we) begin
            r_pal_sel <= i_cfg_wdata;
        end
    end

    // Track whether a write has landed since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_select <= 1'b0;
        end else if (i_cfg_we) begin
            r_palette_select <= 1'b1;
        end
    end

    pqd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (i_item),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_cmd   (push_cmd)
    );

    pqd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_cmd    (pop_cmd)
    );

    pqd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (pop_valid),
        .o_cmd_ready      (pop_ready),
        .i_cmd            (pop_cmd),
        .i_palette_select (r_pal_sel),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_item           (o_item)
    );

    // An accepted pixel pair enters the queue in the same cycle
    a_pixel_pushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_item.op == OP_PIXEL)) |-> (push_valid && push_ready))
        else $error("pixel pair accepted without a queue push");

    // A match request occupies the front end on the following cycle
    a_match_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_item.op == OP_MATCH)) |=> !o_ready)
        else $error("front end ready right after a match request");

    // Emitted cells lie inside the frame
    a_cell_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.cell_index <= LAST_CELL))
        else $error("cell index beyond the frame");

    // Palette select only changes on a config write
    a_sel_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(i_cfg_we) && r_palette_select) |-> $stable(r_pal_sel))
        else $error("palette select changed without a write");

endmodule
